// ===== hw/rtl/mse_pkg.sv =====
// mse_pkg: shared widths, types, state codes and helpers of the merge sort engine
// no dependencies; compiled before every other file of the block
package mse_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WID_W  = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [WID_W-1:0]         wid_t;
    typedef logic [SUM_W-1:0]         sum_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_MERGE,
        S_EMIT_PREP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic merge;
        logic emit_prep;
        logic emit;
    } mse_cmd_t;

    typedef struct packed {
        logic close;
        logic sorted;
        logic pass_end;
        logic emit_done;
    } mse_stat_t;

    // end of a run, limited to the number of stored values
    function automatic cnt_t run_bound(input sum_t a, input cnt_t n);
        cnt_t r;
        if (a > sum_t'(n))
        begin
            r = n;
        end
        else
        begin
            r = a[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mse_if.sv =====
// mse_in_if / mse_out_if: valid-ready channels of the merge sort engine
// depends on mse_pkg for the value type
interface mse_in_if;
    import mse_pkg::*;

    logic  valid;
    logic  ready;
    data_t sort_value;
    logic  is_last;

    modport source (output valid, output sort_value, output is_last, input ready);
    modport sink   (input valid, input sort_value, input is_last, output ready);
endinterface

interface mse_out_if;
    import mse_pkg::*;

    logic  valid;
    logic  ready;
    data_t sorted_value;
    logic  last_out;
    logic  overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

// ===== hw/rtl/mse_datapath.sv =====
// mse_datapath: ping-pong value memories, merge pointers, comparator and output register
// depends on mse_pkg and the channel interfaces in mse_if.sv
module mse_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mse_pkg::mse_cmd_t  cmd,
    output mse_pkg::mse_stat_t stat,
    mse_in_if.sink             sort_in,
    mse_out_if.source          sort_out
);
    import mse_pkg::*;

    data_t mem_a [DEPTH];
    data_t mem_b [DEPTH];

    data_t a_rd0_reg, a_rd1_reg, b_rd0_reg, b_rd1_reg;

    cnt_t  fill_reg, fill_next;
    logic  ovf_reg, ovf_next;
    wid_t  w_reg, w_next;
    logic  src_reg, src_next;
    cnt_t  i_reg, i_next;
    cnt_t  j_reg, j_next;
    cnt_t  k_reg, k_next;
    cnt_t  mid_reg, mid_next;
    cnt_t  hi_reg, hi_next;
    cnt_t  e_reg, e_next;

    data_t out_value_reg, out_value_next;
    logic  out_last_reg, out_last_next;
    logic  out_ovf_reg, out_ovf_next;
    logic  out_valid_reg, out_valid_next;

    cnt_t  addr0, addr1;
    cnt_t  wr_addr;
    data_t wr_data;
    logic  wr_a_en, wr_b_en;

    logic  in_acc, store_en;
    data_t rd_i, rd_j;
    logic  take_j, run_end, pass_end;
    cnt_t  k_inc, e_inc;
    cnt_t  prep_mid, prep_hi, nxt_mid, nxt_hi;
    logic  slot_free;

    assign in_acc   = cmd.load && sort_in.valid;
    assign store_en = in_acc && (fill_reg < cnt_t'(DEPTH));

    assign rd_i = src_reg ? b_rd0_reg : a_rd0_reg;
    assign rd_j = src_reg ? b_rd1_reg : a_rd1_reg;

    // stable merge: the left run wins on a tie
    assign take_j   = (i_reg >= mid_reg) || ((j_reg < hi_reg) && (rd_i > rd_j));
    assign k_inc    = k_reg + cnt_t'(1);
    assign e_inc    = e_reg + cnt_t'(1);
    assign run_end  = (k_inc == hi_reg);
    assign pass_end = run_end && (hi_reg == fill_reg);

    assign prep_mid = run_bound(sum_t'(w_reg), fill_reg);
    assign prep_hi  = run_bound(sum_t'(w_reg) << 1, fill_reg);
    assign nxt_mid  = run_bound(sum_t'(hi_reg) + sum_t'(w_reg), fill_reg);
    assign nxt_hi   = run_bound(sum_t'(hi_reg) + (sum_t'(w_reg) << 1), fill_reg);

    assign slot_free = !out_valid_reg || sort_out.ready;

    assign stat.close     = in_acc && sort_in.is_last;
    assign stat.sorted    = (w_reg >= wid_t'(fill_reg));
    assign stat.pass_end  = cmd.merge && pass_end;
    assign stat.emit_done = cmd.emit && slot_free && (e_inc == fill_reg);

    assign sort_in.ready         = cmd.load;
    assign sort_out.valid        = out_valid_reg;
    assign sort_out.sorted_value = out_value_reg;
    assign sort_out.last_out     = out_last_reg;
    assign sort_out.overflow     = out_ovf_reg;

    always_comb
    begin
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        w_next         = w_reg;
        src_next       = src_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        e_next         = e_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !sort_out.ready;
        addr0          = i_reg;
        addr1          = j_reg;
        wr_addr        = k_reg;
        wr_data        = take_j ? rd_j : rd_i;
        wr_a_en        = 1'b0;
        wr_b_en        = 1'b0;

        // load phase
        if (store_en)
        begin
            fill_next = fill_reg + cnt_t'(1);
            wr_a_en   = 1'b1;
            wr_addr   = fill_reg;
            wr_data   = sort_in.sort_value;
        end
        else if (in_acc)
        begin
            ovf_next = 1'b1;
        end
        if (in_acc && sort_in.is_last)
        begin
            w_next   = wid_t'(1);
            src_next = 1'b0;
        end

        // first run of a pass
        if (cmd.prep)
        begin
            i_next   = '0;
            k_next   = '0;
            mid_next = prep_mid;
            hi_next  = prep_hi;
            j_next   = prep_mid;
            addr0    = '0;
            addr1    = prep_mid;
        end

        // one merged value per cycle
        if (cmd.merge)
        begin
            wr_a_en = src_reg;
            wr_b_en = !src_reg;
            k_next  = k_inc;
            if (run_end && !pass_end)
            begin
                i_next   = hi_reg;
                mid_next = nxt_mid;
                hi_next  = nxt_hi;
                j_next   = nxt_mid;
                addr0    = hi_reg;
                addr1    = nxt_mid;
            end
            else if (take_j)
            begin
                j_next = j_reg + cnt_t'(1);
                addr1  = j_reg + cnt_t'(1);
            end
            else
            begin
                i_next = i_reg + cnt_t'(1);
                addr0  = i_reg + cnt_t'(1);
            end
            if (pass_end)
            begin
                w_next   = w_reg << 1;
                src_next = !src_reg;
            end
        end

        // emit phase
        if (cmd.emit_prep)
        begin
            e_next = '0;
            addr0  = '0;
        end
        if (cmd.emit)
        begin
            addr0 = e_reg;
            if (slot_free)
            begin
                out_value_next = rd_i;
                out_last_next  = (e_inc == fill_reg);
                out_ovf_next   = ovf_reg;
                out_valid_next = 1'b1;
                e_next         = e_inc;
                addr0          = e_inc;
                if (e_inc == fill_reg)
                begin
                    fill_next = '0;
                    ovf_next  = 1'b0;
                end
            end
        end
    end

    // value memories
    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        a_rd0_reg <= mem_a[addr0[ADDR_W-1:0]];
        a_rd1_reg <= mem_a[addr1[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
        begin
            mem_b[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        b_rd0_reg <= mem_b[addr0[ADDR_W-1:0]];
        b_rd1_reg <= mem_b[addr1[ADDR_W-1:0]];
    end

    // pointers and output payload
    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        src_reg       <= src_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        e_reg         <= e_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/mse_controller.sv =====
// mse_controller: phase state machine of the merge sort engine
// depends on mse_pkg for the state, command and status types
module mse_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  mse_pkg::mse_stat_t stat,
    output mse_pkg::mse_cmd_t  cmd
);
    import mse_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (stat.close)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = stat.sorted ? S_EMIT_PREP : S_MERGE;
            end
            S_MERGE:
            begin
                if (stat.pass_end)
                begin
                    state_next = S_PREP;
                end
            end
            S_EMIT_PREP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.emit_done)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_LOAD:      cmd.load      = 1'b1;
            S_PREP:      cmd.prep      = !stat.sorted;
            S_MERGE:     cmd.merge     = 1'b1;
            S_EMIT_PREP: cmd.emit_prep = 1'b1;
            S_EMIT:      cmd.emit      = 1'b1;
            default:     cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/merge_sort_engine.sv =====
// merge_sort_engine: stable ascending merge sort of sets of signed 32-bit values
// depends on mse_pkg, mse_if.sv, mse_controller and mse_datapath
//
//   channel   | dir | payload                                  | beat
//   sort_in   | in  | sort_value, is_last                      | one value of the set
//   sort_out  | out | sorted_value, last_out, overflow         | one sorted value
//
// sort_in is always ready while loading; a set of n values then runs ceil(log2 n)
// merge passes, each merging one value per cycle in the comparator on two
// registered memory reads, then S_PREP finds the set sorted, S_EMIT_PREP sets up
// the read, and it emits one beat per cycle while sort_out does not stall
// sort_in is not ready from the closing beat until the last result is registered
// reset clears the fill count, overflow flag, output valid and phase state only
// a stall on sort_out holds the output register and pauses the emit phase
module merge_sort_engine (
    input  logic      clk,
    input  logic      rst_n,
    mse_in_if.sink    sort_in,
    mse_out_if.source sort_out
);
    import mse_pkg::*;

    mse_cmd_t  cmd;
    mse_stat_t stat;

    mse_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mse_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .sort_in  (sort_in),
        .sort_out (sort_out)
    );

endmodule

// ===== hw/rtl/mse_checker.sv =====
// mse_checker: port-level checks of the merge sort engine, bound to its top level
// depends on mse_pkg for the value type
module mse_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          is_last,
    input logic          out_valid,
    input logic          out_ready,
    input mse_pkg::data_t sorted_value,
    input logic          last_out,
    input logic          overflow
);
    import mse_pkg::*;

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sorted_value)))
        else $error("stalled result changed");

    // input is not ready straight after the closing beat of a set is taken
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && is_last) |=> !in_ready)
        else $error("input taken right after closing beat");

    // the burst runs without gaps and keeps one overflow flag
    a_burst_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_out) |=>
            (out_valid && (overflow == $past(overflow))))
        else $error("gap or flag change inside a result burst");

    // no input is taken while a burst is under way
    a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_out) |-> !in_ready)
        else $error("input ready inside a result burst");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sort_in.valid),
    .in_ready     (sort_in.ready),
    .is_last      (sort_in.is_last),
    .out_valid    (sort_out.valid),
    .out_ready    (sort_out.ready),
    .sorted_value (sort_out.sorted_value),
    .last_out     (sort_out.last_out),
    .overflow     (sort_out.overflow)
);

// ===== test/tb_merge_sort_engine.sv =====
// tb_merge_sort_engine: self-checking testbench of the merge sort engine
// depends on mse_pkg, mse_if.sv and merge_sort_engine; predicts each sorted burst
// and checks every output beat field by field under random idling on both channels
module tb_merge_sort_engine;
    import mse_pkg::*;

    localparam int     QUIET_LIMIT = 5000;
    localparam int     LONG_HOLD   = 400;
    localparam int     DRAIN       = 200;
    localparam int     PHASE_BEATS = 80;
    localparam data_t  VALUE_MIN   = data_t'(32'h8000_0000);
    localparam data_t  VALUE_MAX   = data_t'(32'h7fff_ffff);

    typedef struct {
        data_t value;
        logic  last;
        logic  overflow;
    } sorted_beat_t;

    class sort_scoreboard;
        data_t        open_set[$];
        bit           open_overflow;
        sorted_beat_t sorted_due[$];
        int           failures;

        function void note_value(input data_t v, input logic last);
            data_t        key;
            int           j;
            sorted_beat_t b;
            if (open_set.size() < DEPTH)
            begin
                open_set.push_back(v);
            end
            else
            begin
                open_overflow = 1'b1;
            end
            if (last)
            begin
                // stable insertion sort, ascending signed
                for (int i = 1; i < open_set.size(); i++)
                begin
                    key = open_set[i];
                    j = i - 1;
                    while (j >= 0 && open_set[j] > key)
                    begin
                        open_set[j + 1] = open_set[j];
                        j--;
                    end
                    open_set[j + 1] = key;
                end
                for (int i = 0; i < open_set.size(); i++)
                begin
                    b.value    = open_set[i];
                    b.last     = (i == open_set.size() - 1);
                    b.overflow = open_overflow;
                    sorted_due.push_back(b);
                end
                open_set.delete();
                open_overflow = 1'b0;
            end
        endfunction

        function void check_result(input data_t v, input logic last, input logic ovf);
            sorted_beat_t b;
            if (sorted_due.size() == 0)
            begin
                $error("unexpected beat: sorted_value %0d last_out %0b overflow %0b",
                       v, last, ovf);
                failures++;
                return;
            end
            b = sorted_due.pop_front();
            if (v !== b.value)
            begin
                $error("sorted_value: expected %0d, got %0d", b.value, v);
                failures++;
            end
            if (last !== b.last)
            begin
                $error("last_out: expected %0b, got %0b", b.last, last);
                failures++;
            end
            if (ovf !== b.overflow)
            begin
                $error("overflow: expected %0b, got %0b", b.overflow, ovf);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mse_in_if  sort_in ();
    mse_out_if sort_out ();

    merge_sort_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sort_in  (sort_in.sink),
        .sort_out (sort_out.source)
    );

    sort_scoreboard board;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             idle_phase;
    int             beats_sent;
    int             quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic data_t pick_value(input int spread);
        data_t v;
        case (spread)
            0: v = data_t'($urandom);
            1: v = data_t'($urandom_range(8) - 4);
            default:
            begin
                case ($urandom_range(4))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = data_t'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_beat(input data_t v, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sort_in.valid <= 1'b0;
            @(posedge clk);
        end
        sort_in.valid <= 1'b1;
        sort_in.sort_value <= v;
        sort_in.is_last <= last;
        @(posedge clk);
        while (!sort_in.ready)
        begin
            @(posedge clk);
        end
        board.note_value(v, last);
        beats_sent++;
    endtask

    task automatic send_set(input int n, input int spread);
        for (int i = 0; i < n; i++)
        begin
            send_beat(pick_value(spread), i == n - 1);
        end
    endtask

    task automatic send_listed(input data_t vals[$]);
        for (int i = 0; i < vals.size(); i++)
        begin
            send_beat(vals[i], i == vals.size() - 1);
        end
    endtask

    task automatic send_random_set();
        int n;
        case ($urandom_range(11))
            0: n = DEPTH;
            1: n = $urandom_range(DEPTH + 6, DEPTH + 1);
            default: n = $urandom_range(12, 1);
        endcase
        send_set(n, $urandom_range(2));
    endtask

    // receiver: random ready, one long hold-off once neither side idles
    initial
    begin
        int  hold_left;
        bit  long_hold_done;
        hold_left = 0;
        long_hold_done = 0;
        sort_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sort_out.valid && sort_out.ready)
            begin
                board.check_result(sort_out.sorted_value, sort_out.last_out,
                                   sort_out.overflow);
            end
            if (idle_phase == 2 && !long_hold_done)
            begin
                long_hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                sort_out.ready <= 1'b0;
            end
            else
            begin
                sort_out.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sort_in.valid && sort_in.ready) || (sort_out.valid && sort_out.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sort_in.valid = 1'b0;
        sort_in.sort_value = '0;
        sort_in.is_last = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        idle_phase = 0;
        beats_sent = 0;
        board = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets: single extremes, ties, reversed order
        send_listed('{VALUE_MIN});
        send_listed('{VALUE_MAX});
        send_listed('{data_t'(0), data_t'(-1), data_t'(1), VALUE_MAX, VALUE_MIN,
                      VALUE_MIN, VALUE_MAX});
        send_listed('{data_t'(5), data_t'(4), data_t'(3), data_t'(2), data_t'(1)});
        send_listed('{data_t'(7), data_t'(7), data_t'(-7), data_t'(7)});
        send_listed('{data_t'(32'h7fff_fffe), data_t'(32'h8000_0001)});

        // a set filling the store exactly, then one that overflows and drops its last three values
        send_set(DEPTH, 0);
        send_set(DEPTH + 3, 2);

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct <= 25;
                    rx_idle_pct <= 84;
                end
                1:
                begin
                    tx_idle_pct <= 84;
                    rx_idle_pct <= 25;
                end
                default:
                begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            idle_phase <= p;
            beats_sent = 0;
            while (beats_sent < PHASE_BEATS)
            begin
                send_random_set();
            end
        end
        sort_in.valid <= 1'b0;

        while (board.sorted_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
        if (board.sorted_due.size() != 0 || board.open_set.size() != 0)
        begin
            $error("%0d sorted beats never arrived", board.sorted_due.size());
            board.failures++;
        end
        if (board.failures == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_if.sv
hw/rtl/mse_datapath.sv
hw/rtl/mse_controller.sv
hw/rtl/merge_sort_engine.sv
hw/rtl/mse_checker.sv
test/tb_merge_sort_engine.sv
